// ----- sv/fault_escalation_supervisor_defines.svh -----
// Assertion macros for the fault escalation supervisor
`ifndef FAULT_ESCALATION_SUPERVISOR_DEFINES_SVH
`define FAULT_ESCALATION_SUPERVISOR_DEFINES_SVH

// Check a property on every rising edge outside reset
`define FES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence
`define FES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fes_pkg.sv -----
// Shared types and constants of the fault escalation supervisor
package fes_pkg;

  localparam int unsigned TOTAL_BITS = 32;
  localparam int unsigned OUT_TOTAL_BITS = 32;
  localparam int unsigned THR_BITS = 8;
  localparam int unsigned CNT_BITS = 8;
  localparam int unsigned REASON_BITS = 4;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(3);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ESCALATE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECOVERY = 1'b1;

  typedef enum logic [1:0] {
    ACT_REPORT  = 2'd0,
    ACT_SUCCESS = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LEVEL_OK       = 2'd0,
    LEVEL_DEGRADED = 2'd1,
    LEVEL_FAULT    = 2'd2
  } level_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [REASON_BITS-1:0] reason_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                level;
    logic [REASON_BITS-1:0]    last_reason;
    logic [OUT_TOTAL_BITS-1:0] incident_total;
    logic [CNT_BITS-1:0]       recent_count;
  } out_word_t;

  typedef struct packed {
    level_e                 level;
    logic [REASON_BITS-1:0] reason;
    logic [TOTAL_BITS-1:0]  total;
    logic [CNT_BITS-1:0]    recent;
    logic [CNT_BITS-1:0]    run;
  } state_t;

endpackage

// ----- sv/fes_in_if.sv -----
// Event channel of the fault escalation supervisor
interface fes_in_if;
  logic               valid;
  logic               ready;
  fes_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/fes_out_if.sv -----
// Result channel of the fault escalation supervisor
interface fes_out_if;
  logic               valid;
  logic               ready;
  fes_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/fes_update.sv -----
// Next-state logic for one event of the fault escalation supervisor
module fes_update (
  input  fes_pkg::state_t                 state_i,
  input  fes_pkg::in_word_t               word_i,
  input  logic [fes_pkg::THR_BITS-1:0]    esc_thr_i,
  input  logic [fes_pkg::THR_BITS-1:0]    rec_thr_i,
  output fes_pkg::state_t                 state_o
);

  localparam logic [fes_pkg::CNT_BITS-1:0] CntMax = '1;

  logic [fes_pkg::CNT_BITS-1:0] recent_inc;
  logic [fes_pkg::CNT_BITS-1:0] run_inc;
  logic [fes_pkg::CNT_BITS-1:0] recent_dec;

  assign recent_inc = (state_i.recent == CntMax) ? state_i.recent
                                                 : state_i.recent + 1'b1;
  assign run_inc    = (state_i.run == CntMax) ? state_i.run : state_i.run + 1'b1;
  assign recent_dec = (state_i.recent == '0) ? state_i.recent : state_i.recent - 1'b1;

  always_comb begin
    state_o = state_i;
    case (fes_pkg::action_e'(word_i.action))
      fes_pkg::ACT_REPORT: begin
        state_o.total  = state_i.total + 1'b1;
        state_o.run    = '0;
        state_o.reason = word_i.reason_code;
        if (state_i.level != fes_pkg::LEVEL_FAULT) begin
          state_o.recent = recent_inc;
          state_o.level  = (recent_inc >= esc_thr_i) ? fes_pkg::LEVEL_FAULT
                                                     : fes_pkg::LEVEL_DEGRADED;
        end
      end
      fes_pkg::ACT_SUCCESS: begin
        if (state_i.level == fes_pkg::LEVEL_DEGRADED) begin
          state_o.run = run_inc;
          if (run_inc >= rec_thr_i) begin
            state_o.level  = fes_pkg::LEVEL_OK;
            state_o.reason = '0;
            state_o.recent = '0;
          end
        end else if (state_i.level == fes_pkg::LEVEL_OK) begin
          state_o.recent = recent_dec;
        end
      end
      fes_pkg::ACT_CLEAR: begin
        state_o.level  = fes_pkg::LEVEL_OK;
        state_o.reason = '0;
        state_o.recent = '0;
        state_o.run    = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ----- sv/fault_escalation_supervisor.sv -----
// Top level of the fault escalation supervisor
//
//   channel   dir  handshake      word
//   in_i      in   valid/ready    action, reason_code
//   out_o     out  valid/ready    level, last_reason, incident_total, recent_count
//   cfg       in   cfg_we_i       cfg_idx_i selects threshold, cfg_wdata_i value
//
// An accepted word passes through an input register, then the state update and result
// register. One word is taken every cycle while results drain.
// Reset clears the level, counters and reason, and sets both thresholds to 3.
// A stalled result holds the pipeline; the input register still takes one word.
`include "fault_escalation_supervisor_defines.svh"

module fault_escalation_supervisor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fes_in_if.sink                            in_i,
  fes_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [fes_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [fes_pkg::THR_BITS-1:0]      cfg_wdata_i
);

  logic                          in_valid_q;
  fes_pkg::in_word_t             in_word_q;
  logic                          out_valid_q;
  fes_pkg::out_word_t            out_q;
  fes_pkg::out_word_t            out_d;
  fes_pkg::state_t               state_q;
  fes_pkg::state_t               state_d;
  logic [fes_pkg::THR_BITS-1:0]  esc_thr_q;
  logic [fes_pkg::THR_BITS-1:0]  rec_thr_q;
  logic                          advance;
  logic                          in_ready;

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  fes_update u_update (
    .state_i   (state_q),
    .word_i    (in_word_q),
    .esc_thr_i (esc_thr_q),
    .rec_thr_i (rec_thr_q),
    .state_o   (state_d)
  );

  always_comb begin
    out_d.level          = state_d.level;
    out_d.last_reason    = state_d.reason;
    out_d.incident_total = fes_pkg::OUT_TOTAL_BITS'(state_d.total);
    out_d.recent_count   = state_d.recent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{level: fes_pkg::LEVEL_OK, default: '0};
      esc_thr_q   <= fes_pkg::THRESHOLD_RESET;
      rec_thr_q   <= fes_pkg::THRESHOLD_RESET;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fes_pkg::CFG_ESCALATE: esc_thr_q <= cfg_wdata_i;
          fes_pkg::CFG_RECOVERY: rec_thr_q <= cfg_wdata_i;
          default: begin
            esc_thr_q <= esc_thr_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_word_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  `FES_ASSERT_NEXT(a_total_step, clk_i, rst_ni, advance && (in_word_q.action == fes_pkg::ACT_REPORT), state_q.total == $past(state_q.total) + 1'b1, "total did not advance on a report")
  `FES_ASSERT_NEXT(a_fault_latch, clk_i, rst_ni, (state_q.level == fes_pkg::LEVEL_FAULT) && !(advance && (in_word_q.action == fes_pkg::ACT_CLEAR)), state_q.level == fes_pkg::LEVEL_FAULT, "fault level left without a clear")
  `FES_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, advance, out_valid_q && (out_q.level == state_q.level) && (out_q.recent_count == state_q.recent), "result does not match state")
  `FES_ASSERT(a_ok_no_reason, clk_i, rst_ni, !((state_q.level == fes_pkg::LEVEL_OK) && (state_q.reason != '0)), "reason kept in OK")

endmodule

// ----- test/fault_escalation_supervisor_checker.sv -----
// Checker for the fault escalation supervisor: predicts each result word and compares it
`timescale 1ns / 1ps
module fault_escalation_supervisor_checker
  import fes_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  fes_in_if                       evt_i,
  fes_out_if                      res_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [THR_BITS-1:0]     cfg_wdata_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output int unsigned             checked_o
);

  logic [THR_BITS-1:0] escalate_thr;
  logic [THR_BITS-1:0] recovery_thr;
  state_t              sup_state;
  out_word_t           expected_q[$];

  function automatic out_word_t apply_event(input in_word_t w);
    out_word_t r;
    case (w.action)
      ACT_REPORT: begin
        sup_state.total  = sup_state.total + 1'b1;
        sup_state.run    = '0;
        sup_state.reason = w.reason_code;
        if (sup_state.level != LEVEL_FAULT) begin
          if (sup_state.recent != '1) sup_state.recent = sup_state.recent + 1'b1;
          sup_state.level = (sup_state.recent >= escalate_thr) ? LEVEL_FAULT : LEVEL_DEGRADED;
        end
      end
      ACT_SUCCESS: begin
        if (sup_state.level == LEVEL_DEGRADED) begin
          if (sup_state.run != '1) sup_state.run = sup_state.run + 1'b1;
          if (sup_state.run >= recovery_thr) begin
            sup_state.level  = LEVEL_OK;
            sup_state.reason = '0;
            sup_state.recent = '0;
          end
        end else if (sup_state.level == LEVEL_OK && sup_state.recent != '0) begin
          sup_state.recent = sup_state.recent - 1'b1;
        end
      end
      ACT_CLEAR: begin
        sup_state.level  = LEVEL_OK;
        sup_state.reason = '0;
        sup_state.recent = '0;
        sup_state.run    = '0;
      end
      default: ;
    endcase
    r.level          = sup_state.level;
    r.last_reason    = sup_state.reason;
    r.incident_total = sup_state.total[OUT_TOTAL_BITS-1:0];
    r.recent_count   = sup_state.recent;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      escalate_thr = THRESHOLD_RESET;
      recovery_thr = THRESHOLD_RESET;
      sup_state    = '0;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ESCALATE) escalate_thr = cfg_wdata_i;
        else recovery_thr = cfg_wdata_i;
      end
      if (evt_i.valid && evt_i.ready) expected_q.push_back(apply_event(evt_i.data));
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time, res_i.data);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          compare_field("level", 32'(want.level), 32'(res_i.data.level));
          compare_field("last_reason", 32'(want.last_reason), 32'(res_i.data.last_reason));
          compare_field("incident_total", want.incident_total, res_i.data.incident_total);
          compare_field("recent_count", 32'(want.recent_count), 32'(res_i.data.recent_count));
          checked_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- test/fault_escalation_supervisor_tb.sv -----
// Testbench top: drives events and thresholds into the fault escalation supervisor
`timescale 1ns / 1ps
module fault_escalation_supervisor_tb;
  import fes_pkg::*;

  localparam int unsigned LATENCY        = 2;
  localparam int unsigned HOLD_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned PHASE_WORDS    = 170;
  localparam int unsigned TAIL_WORDS     = 120;
  localparam int unsigned SAT_COUNT      = 255;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [THR_BITS-1:0]     cfg_wdata;
  bit                      idle_on;
  bit                      hold_req;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             checked;
  int unsigned             sent;
  int unsigned             settings_used;
  int unsigned             quiet_cycles;

  fes_in_if  evt_if();
  fes_out_if res_if();

  fault_escalation_supervisor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (evt_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  fault_escalation_supervisor_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .evt_i        (evt_if),
    .res_i        (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("fault_escalation_supervisor_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input action_e act, input logic [REASON_BITS-1:0] rsn);
    in_word_t    w;
    int unsigned gap;
    w.action      = act;
    w.reason_code = rsn;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      evt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_if.valid <= 1'b1;
    evt_if.data  <= w;
    do @(posedge clk); while (!evt_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random();
    int unsigned            pick;
    logic [REASON_BITS-1:0] rsn;
    pick = $urandom_range(0, 99);
    rsn  = REASON_BITS'($urandom);
    if (pick < 40) send_word(ACT_REPORT, rsn);
    else if (pick < 85) send_word(ACT_SUCCESS, rsn);
    else if (pick < 93) send_word(ACT_CLEAR, rsn);
    else send_word(ACT_NONE, rsn);
  endtask

  task automatic drain();
    evt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [THR_BITS-1:0] esc, input logic [THR_BITS-1:0] rec);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ESCALATE;
    cfg_wdata <= esc;
    @(negedge clk);
    cfg_idx   <= CFG_RECOVERY;
    cfg_wdata <= rec;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [THR_BITS-1:0] esc;
    evt_if.valid = 1'b0;
    evt_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_ESCALATE;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds: recovery, latching, latched report and success, clears
    send_word(ACT_REPORT, 4'hF);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_SUCCESS, 4'hF);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_REPORT, 4'h0);
    send_word(ACT_REPORT, 4'h5);
    send_word(ACT_SUCCESS, 4'hA);
    send_word(ACT_CLEAR, 4'h3);
    send_word(ACT_REPORT, 4'h1);
    send_word(ACT_REPORT, 4'h2);
    send_word(ACT_REPORT, 4'h3);
    send_word(ACT_REPORT, 4'hA);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_NONE, 4'hF);
    send_word(ACT_CLEAR, 4'h0);
    send_word(ACT_NONE, 4'h6);
    drain();

    set_thresholds(8'd2, 8'd1);
    send_word(ACT_REPORT, 4'h7);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_REPORT, 4'h3);
    send_word(ACT_REPORT, 4'hC);
    send_word(ACT_CLEAR, 4'h0);
    drain();

    set_thresholds(8'd1, 8'd2);
    send_word(ACT_REPORT, 4'h4);
    send_word(ACT_CLEAR, 4'h0);
    drain();

    set_thresholds(8'd0, 8'd2);
    send_word(ACT_REPORT, 4'h6);
    send_word(ACT_CLEAR, 4'h0);
    drain();

    set_thresholds(8'd4, 8'd0);
    send_word(ACT_REPORT, 4'h9);
    send_word(ACT_SUCCESS, 4'h0);
    send_word(ACT_SUCCESS, 4'h0);
    drain();

    // climb both counters to their top value
    set_thresholds(8'd255, 8'd255);
    repeat (SAT_COUNT + 1) send_word(ACT_REPORT, REASON_BITS'($urandom));
    send_word(ACT_CLEAR, 4'h0);
    send_word(ACT_REPORT, 4'hE);
    repeat (SAT_COUNT + 1) send_word(ACT_SUCCESS, REASON_BITS'($urandom));
    drain();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase % 3 == 2) set_thresholds(THR_BITS'($urandom_range(1, 255)),
                                         THR_BITS'($urandom_range(1, 255)));
      else set_thresholds(THR_BITS'($urandom_range(1, 8)), THR_BITS'($urandom_range(1, 8)));
      idle_on = (phase != 3);
      if (phase == 4) hold_req = 1'b1;
      repeat (PHASE_WORDS) send_random();
      drain();
    end

    esc = THR_BITS'($urandom_range(1, 6));
    set_thresholds(esc, THR_BITS'($urandom_range(1, 6)));
    idle_on = 1'b0;
    repeat (TAIL_WORDS) send_random();

    evt_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("Run sent %0d events under %0d threshold settings and checked %0d results.",
             sent, settings_used, checked);
    $display("It covered recovery, latching, clears, unused actions, zero and top thresholds, and long output back-pressure.");
    if (fail_count == 0) begin
      $display("fault_escalation_supervisor_tb: PASS");
    end else begin
      $display("fault_escalation_supervisor_tb: FAIL");
    end
    $finish;
  end

endmodule
